[rtl/alsb_pkg.sv]
// ----------------------------------------------------------------------------
// alsb_pkg
// Shared types, constants and helpers of the alarm slot beeper unit.
// ----------------------------------------------------------------------------
package alsb_pkg;

  // slot and burst sizing
  localparam int SLOT_COUNT  = 8;
  localparam int ALARM_BURST = 4;
  localparam int CHIME_BURST = 2;

  // field widths
  localparam int SLOT_LANES     = 8;
  localparam int MODE_W         = 2;
  localparam int DAY_W          = 16;
  localparam int SEC_W          = 17;
  localparam int TIMER_W        = 10;
  localparam int COUNT_W        = 3;
  localparam int TIME_REG_W     = 2 * SEC_W;
  localparam int TIME_REG_COUNT = 4;

  // configuration port
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  // register reset values
  localparam logic [TIMER_W-1:0] SHORT_RESET = 10'd75;
  localparam logic [TIMER_W-1:0] LONG_RESET  = 10'd700;

  // item modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACK   = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_SLOT_A = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLOT_B = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SLOT_C = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SLOT_D = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CHIME  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SHORT  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_LONG   = 3'd7;

  // hour marks reachable by a raw seconds value
  localparam int SECS_PER_HOUR = 3600;
  localparam int HOUR_MARKS    = ((1 << SEC_W) - 1) / SECS_PER_HOUR + 1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DAY_W-1:0]  day_number;
    logic [SEC_W-1:0]  seconds_of_day;
    logic              clock_valid;
  } alsb_item_t;

  typedef struct packed {
    logic [TIME_REG_COUNT-1:0][TIME_REG_W-1:0] slot_times;
    logic [SLOT_LANES-1:0]                     slot_enable;
    logic                                      chime_enable;
    logic [TIMER_W-1:0]                        short_interval;
    logic [TIMER_W-1:0]                        long_interval;
  } alsb_cfg_t;

  // decoded strobes for the item being retired this cycle
  typedef struct packed {
    logic tick;
    logic check;
    logic ack;
  } alsb_step_t;

  // true when seconds is an exact multiple of one hour
  function automatic logic hour_mark(input logic [SEC_W-1:0] sod);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < HOUR_MARKS; k++) begin
      if (sod == SEC_W'(k * SECS_PER_HOUR)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

[rtl/alsb_in_if.sv]
// ----------------------------------------------------------------------------
// alsb_in_if
// Input channel: valid/ready handshake with the time and mode payload.
// ----------------------------------------------------------------------------
interface alsb_in_if;
  import alsb_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [DAY_W-1:0]  day_number;
  logic [SEC_W-1:0]  seconds_of_day;
  logic              clock_valid;

  modport source (output valid, mode, day_number, seconds_of_day, clock_valid,
                  input ready);
  modport sink   (input valid, mode, day_number, seconds_of_day, clock_valid,
                  output ready);
endinterface

[rtl/alsb_out_if.sv]
// ----------------------------------------------------------------------------
// alsb_out_if
// Result channel: valid/ready handshake with beeper and alarm status.
// ----------------------------------------------------------------------------
interface alsb_out_if;
  import alsb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  beeper_on;
  logic [SLOT_LANES-1:0] active_alarms;
  logic                  chime_active;

  modport source (output valid, beeper_on, active_alarms, chime_active,
                  input ready);
  modport sink   (input valid, beeper_on, active_alarms, chime_active,
                  output ready);
endinterface

[rtl/alsb_cfg.sv]
// ----------------------------------------------------------------------------
// alsb_cfg
// APB register file holding slot times, enables and cadence intervals.
// ----------------------------------------------------------------------------
module alsb_cfg
  import alsb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output alsb_cfg_t             cfg
);

  alsb_cfg_t            cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slot_times     <= '0;
      cfg_r.slot_enable    <= '0;
      cfg_r.chime_enable   <= 1'b0;
      cfg_r.short_interval <= SHORT_RESET;
      cfg_r.long_interval  <= LONG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SLOT_A: cfg_r.slot_times[0] <= pwdata[TIME_REG_W-1:0];
        REG_SLOT_B: cfg_r.slot_times[1] <= pwdata[TIME_REG_W-1:0];
        REG_SLOT_C: cfg_r.slot_times[2] <= pwdata[TIME_REG_W-1:0];
        REG_SLOT_D: cfg_r.slot_times[3] <= pwdata[TIME_REG_W-1:0];
        REG_ENABLE: cfg_r.slot_enable <= pwdata[SLOT_LANES-1:0];
        REG_CHIME:  cfg_r.chime_enable <= pwdata[0];
        REG_SHORT:  cfg_r.short_interval <= pwdata[TIMER_W-1:0];
        REG_LONG:   cfg_r.long_interval <= pwdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_SLOT_A: prdata[TIME_REG_W-1:0] = cfg_r.slot_times[0];
      REG_SLOT_B: prdata[TIME_REG_W-1:0] = cfg_r.slot_times[1];
      REG_SLOT_C: prdata[TIME_REG_W-1:0] = cfg_r.slot_times[2];
      REG_SLOT_D: prdata[TIME_REG_W-1:0] = cfg_r.slot_times[3];
      REG_ENABLE: prdata[SLOT_LANES-1:0] = cfg_r.slot_enable;
      REG_CHIME:  prdata[0] = cfg_r.chime_enable;
      REG_SHORT:  prdata[TIMER_W-1:0] = cfg_r.short_interval;
      REG_LONG:   prdata[TIMER_W-1:0] = cfg_r.long_interval;
      default:    prdata = '0;
    endcase
  end

endmodule

[rtl/alsb_slots.sv]
// ----------------------------------------------------------------------------
// alsb_slots
// Per-slot time compare, acknowledgement stamps and the active alarm mask.
// ----------------------------------------------------------------------------
module alsb_slots
  import alsb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  alsb_step_t            step,
  input  alsb_item_t            item,
  input  alsb_cfg_t             cfg,
  output logic [SLOT_LANES-1:0] active_mask
);

  logic [DAY_W-1:0]      ack_day_r [SLOT_LANES];
  logic [SEC_W-1:0]      ack_sec_r [SLOT_LANES];
  logic [SLOT_LANES-1:0] active_mask_r;
  logic [SLOT_LANES-1:0] fire;

  assign active_mask = active_mask_r;

  // one compare lane per slot, all in parallel
  for (genvar i = 0; i < SLOT_LANES; i++) begin : g_lane
    if (i < SLOT_COUNT) begin : g_used
      logic [SEC_W-1:0] slot_time;
      logic             reached;
      logic             earlier;

      assign slot_time = cfg.slot_times[i / 2][(i % 2) * SEC_W +: SEC_W];
      assign reached   = item.seconds_of_day >= slot_time;
      assign earlier   = (ack_day_r[i] < item.day_number) ||
                         ((ack_day_r[i] == item.day_number) &&
                          (ack_sec_r[i] < slot_time));
      assign fire[i]   = cfg.slot_enable[i] && reached && earlier;
    end else begin : g_unused
      assign fire[i] = 1'b0;
    end
  end

  // stamp on acknowledge, set bits on a valid time check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_mask_r <= '0;
      for (int i = 0; i < SLOT_LANES; i++) begin
        ack_day_r[i] <= '0;
        ack_sec_r[i] <= '0;
      end
    end else if (step.ack) begin
      for (int i = 0; i < SLOT_LANES; i++) begin
        if (active_mask_r[i]) begin
          ack_day_r[i] <= item.day_number;
          ack_sec_r[i] <= item.seconds_of_day;
        end
      end
      active_mask_r <= '0;
    end else if (step.check && item.clock_valid) begin
      active_mask_r <= active_mask_r | fire;
    end
  end

endmodule

[rtl/alsb_beep.sv]
// ----------------------------------------------------------------------------
// alsb_beep
// Beep cadence generator and hourly chime flag.
// ----------------------------------------------------------------------------
module alsb_beep
  import alsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  alsb_step_t step,
  input  alsb_item_t item,
  input  alsb_cfg_t  cfg,
  input  logic       alarm_any,
  output logic       beeper_on,
  output logic       chime_active
);

  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               beeper_r, beeper_nxt;
  logic               chime_r, chime_nxt;

  logic [COUNT_W-1:0] burst;
  logic               long_phase;
  logic               expired;
  logic [TIMER_W-1:0] limit;
  logic               run;

  assign beeper_on    = beeper_r;
  assign chime_active = chime_r;

  // cadence step decode
  assign burst      = alarm_any ? COUNT_W'(ALARM_BURST) : COUNT_W'(CHIME_BURST);
  assign long_phase = count_r >= burst;
  assign limit      = long_phase ? cfg.long_interval : cfg.short_interval;
  assign expired    = timer_r >= limit;
  assign run        = alarm_any || chime_r;

  always_comb begin
    timer_nxt  = timer_r;
    count_nxt  = count_r;
    beeper_nxt = beeper_r;
    chime_nxt  = chime_r;
    if (step.tick) begin
      if (run) begin
        // alarm cancels the chime
        if (alarm_any) chime_nxt = 1'b0;
        if (expired) begin
          timer_nxt = '0;
          if (long_phase) begin
            count_nxt = '0;
            // end of the chime pause retires the chime
            if (!alarm_any) chime_nxt = 1'b0;
          end else if (beeper_r) begin
            beeper_nxt = 1'b0;
            count_nxt  = count_r + COUNT_W'(1);
          end else begin
            beeper_nxt = 1'b1;
          end
        end else begin
          timer_nxt = timer_r + TIMER_W'(1);
        end
      end else begin
        beeper_nxt = 1'b0;
      end
    end else if (step.check) begin
      if (item.clock_valid && cfg.chime_enable && hour_mark(item.seconds_of_day)) begin
        chime_nxt = 1'b1;
      end
    end else if (step.ack) begin
      timer_nxt = '0;
      count_nxt = '0;
    end
  end

  // state registers, chime armed at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r  <= '0;
      count_r  <= '0;
      beeper_r <= 1'b0;
      chime_r  <= 1'b1;
    end else begin
      timer_r  <= timer_nxt;
      count_r  <= count_nxt;
      beeper_r <= beeper_nxt;
      chime_r  <= chime_nxt;
    end
  end

endmodule

[rtl/alarm_slot_beeper_unit.sv]
// ----------------------------------------------------------------------------
// alarm_slot_beeper_unit
// Eight-slot daily alarm with hourly chime and beep cadence generator.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in_chan   sink       valid/ready        mode, day_number, seconds_of_day,
//                                          clock_valid
//  out_chan  source     valid/ready        beeper_on, active_alarms,
//                                          chime_active
//  apb       slave      psel/penable       64-bit registers at 8*index
//
//  One transaction per cycle sustained while out_chan is ready; each result
//  passes the input register, then the state/result register.
//  The state registers double as the result register; a stalled result
//  holds the input register, and in_chan.ready drops only when both are full.
//  Synchronous active-low reset; the hourly chime comes up armed.
// ----------------------------------------------------------------------------
module alarm_slot_beeper_unit
  import alsb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  alsb_in_if.sink               in_chan,
  alsb_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  alsb_cfg_t             cfg;
  alsb_item_t            item_r;
  logic                  item_valid_r;
  logic                  out_valid_r;
  logic                  advance;
  logic                  in_take;
  alsb_step_t            step;
  logic [SLOT_LANES-1:0] active_mask;

  // pipeline flow
  assign advance       = item_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !item_valid_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      item_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode           <= in_chan.mode;
      item_r.day_number     <= in_chan.day_number;
      item_r.seconds_of_day <= in_chan.seconds_of_day;
      item_r.clock_valid    <= in_chan.clock_valid;
    end
  end

  // result valid tracks the state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // mode decode, only while the item retires
  assign step.tick  = advance && (item_r.mode == MODE_TICK);
  assign step.check = advance && (item_r.mode == MODE_CHECK);
  assign step.ack   = advance && (item_r.mode == MODE_ACK);

  alsb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  alsb_slots u_slots (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (item_r),
    .cfg         (cfg),
    .active_mask (active_mask)
  );

  alsb_beep u_beep (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .item         (item_r),
    .cfg          (cfg),
    .alarm_any    (|active_mask),
    .beeper_on    (out_chan.beeper_on),
    .chime_active (out_chan.chime_active)
  );

  assign out_chan.valid         = out_valid_r;
  assign out_chan.active_alarms = active_mask;

endmodule

[verif/alarm_slot_beeper_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alarm_slot_beeper_unit_tb
// Self-checking bench for the alarm slot beeper unit. A directed table walks
// the corner cases, then random phases run well-formed alarm days with ticks,
// time checks and acknowledges under new register settings. Every result
// is checked against a cycle-free model of the alarm state or a typed row's status.
// ----------------------------------------------------------------------------
module alarm_slot_beeper_unit_tb;
  import alsb_pkg::*;

  localparam int                CLK_HALF      = 4;
  localparam int                RESET_CYCLES  = 8;
  localparam int                SETTLE_CYCLES = 6;
  localparam int                PHASE_ITEMS   = 120;
  localparam int                PHASE_COUNT   = 7;
  localparam int                DIR_ROWS      = 22;
  localparam int                SECS_PER_DAY  = 86400;
  localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

  typedef struct packed {
    logic                  beeper;
    logic [SLOT_LANES-1:0] alarms;
    logic                  chime;
  } status_t;

  typedef struct packed {
    alsb_item_t item;
    logic       typed;
    status_t    want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  alsb_in_if  in_chan ();
  alsb_out_if out_chan ();

  alarm_slot_beeper_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // model copy of the registers
  logic [TIME_REG_W-1:0] slot_reg_q [TIME_REG_COUNT];
  logic [SLOT_LANES-1:0] slot_en_q;
  logic                  chime_en_q;
  logic [TIMER_W-1:0]    short_q;
  logic [TIMER_W-1:0]    long_q;

  // model copy of the alarm and beeper state
  logic [DAY_W-1:0]      ack_day_q [SLOT_LANES];
  logic [SEC_W-1:0]      ack_sec_q [SLOT_LANES];
  logic [SLOT_LANES-1:0] active_q;
  logic                  chime_q;
  logic [TIMER_W-1:0]    timer_q;
  logic [COUNT_W-1:0]    count_q;
  logic                  beeper_q;

  status_t status_q [$];
  int      error_count;
  int      result_count;
  int      burst_left;
  int      wall_day;
  int      wall_sod;
  int      recv_cycle = 0;

  // directed corner cases; typed rows carry their expected status
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{MODE_UNUSED, 16'd0,     17'd0,      1'b0}, 1'b1, '{1'b0, 8'h00, 1'b1}},
    '{'{MODE_CHECK,  16'd65535, 17'd131071, 1'b0}, 1'b1, '{1'b0, 8'h00, 1'b1}},
    '{'{MODE_TICK,   16'd65535, 17'd131071, 1'b1}, 1'b0, '0},
    '{'{MODE_TICK,   16'd0,     17'd0,      1'b0}, 1'b0, '0},
    '{'{MODE_TICK,   16'd0,     17'd0,      1'b0}, 1'b0, '0},
    '{'{MODE_TICK,   16'd0,     17'd0,      1'b0}, 1'b0, '0},
    '{'{MODE_TICK,   16'd0,     17'd0,      1'b0}, 1'b0, '0},
    '{'{MODE_TICK,   16'd0,     17'd0,      1'b0}, 1'b0, '0},
    '{'{MODE_CHECK,  16'd0,     17'd0,      1'b1}, 1'b0, '0},
    '{'{MODE_CHECK,  16'd1,     17'd0,      1'b1}, 1'b0, '0},
    '{'{MODE_TICK,   16'd0,     17'd0,      1'b0}, 1'b0, '0},
    '{'{MODE_TICK,   16'd0,     17'd0,      1'b0}, 1'b0, '0},
    '{'{MODE_ACK,    16'd1,     17'd0,      1'b0}, 1'b0, '0},
    '{'{MODE_CHECK,  16'd1,     17'd3600,   1'b1}, 1'b0, '0},
    '{'{MODE_ACK,    16'd1,     17'd3600,   1'b1}, 1'b0, '0},
    '{'{MODE_CHECK,  16'd65535, 17'd86399,  1'b1}, 1'b0, '0},
    '{'{MODE_TICK,   16'd0,     17'd0,      1'b0}, 1'b0, '0},
    '{'{MODE_CHECK,  16'd65535, 17'd129600, 1'b1}, 1'b0, '0},
    '{'{MODE_ACK,    16'd65535, 17'd131071, 1'b1}, 1'b0, '0},
    '{'{MODE_UNUSED, 16'd12345, 17'd777,    1'b1}, 1'b0, '0},
    '{'{MODE_CHECK,  16'd0,     17'd0,      1'b1}, 1'b0, '0},
    '{'{MODE_TICK,   16'd0,     17'd0,      1'b0}, 1'b0, '0}
  };

  // clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // alarm state model
  // ---------------------------------------------------------------------------
  task automatic reset_alarm_model();
    for (int i = 0; i < TIME_REG_COUNT; i++) slot_reg_q[i] = '0;
    for (int i = 0; i < SLOT_LANES; i++) begin
      ack_day_q[i] = '0;
      ack_sec_q[i] = '0;
    end
    slot_en_q  = '0;
    chime_en_q = 1'b0;
    short_q    = SHORT_RESET;
    long_q     = LONG_RESET;
    active_q   = '0;
    chime_q    = 1'b1;
    timer_q    = '0;
    count_q    = '0;
    beeper_q   = 1'b0;
  endtask

  function automatic logic [SEC_W-1:0] slot_time(input int slot);
    logic [TIME_REG_W-1:0] packed_times;
    packed_times = slot_reg_q[slot / 2];
    return (slot % 2) ? packed_times[TIME_REG_W-1:SEC_W] : packed_times[SEC_W-1:0];
  endfunction

  // one beep cadence step; true when the long pause just ran out
  function automatic logic cadence_step(input int burst);
    logic [TIMER_W-1:0] old_timer;
    old_timer = timer_q;
    if (int'(count_q) >= burst) begin
      if (old_timer >= long_q) begin
        count_q = '0;
        timer_q = '0;
        return 1'b1;
      end
      timer_q = old_timer + 1'b1;
    end else if (old_timer >= short_q) begin
      timer_q = '0;
      if (beeper_q) begin
        beeper_q = 1'b0;
        count_q  = count_q + 1'b1;
      end else begin
        beeper_q = 1'b1;
      end
    end else begin
      timer_q = old_timer + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic status_t predict_status(input alsb_item_t it);
    logic [SEC_W-1:0] t;
    logic             earlier;
    case (it.mode)
      MODE_TICK: begin
        if (active_q != '0) begin
          chime_q = 1'b0;
          void'(cadence_step(ALARM_BURST));
        end else if (chime_q) begin
          if (cadence_step(CHIME_BURST)) chime_q = 1'b0;
        end else begin
          beeper_q = 1'b0;
        end
      end
      MODE_CHECK: begin
        if (it.clock_valid) begin
          if (chime_en_q && (int'(it.seconds_of_day) % SECS_PER_HOUR) == 0) chime_q = 1'b1;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            t = slot_time(i);
            earlier = (ack_day_q[i] < it.day_number) ||
                      (ack_day_q[i] == it.day_number && ack_sec_q[i] < t);
            if (slot_en_q[i] && it.seconds_of_day >= t && earlier) active_q[i] = 1'b1;
          end
        end
      end
      MODE_ACK: begin
        for (int i = 0; i < SLOT_LANES; i++) begin
          if (active_q[i]) begin
            ack_day_q[i] = it.day_number;
            ack_sec_q[i] = it.seconds_of_day;
          end
        end
        active_q = '0;
        count_q  = '0;
        timer_q  = '0;
      end
      default: ;
    endcase
    return '{beeper_q, active_q, chime_q};
  endfunction

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SLOT_A, REG_SLOT_B, REG_SLOT_C, REG_SLOT_D: slot_reg_q[idx[1:0]] = value[TIME_REG_W-1:0];
      REG_ENABLE: slot_en_q  = value[SLOT_LANES-1:0];
      REG_CHIME:  chime_en_q = value[0];
      REG_SHORT:  short_q    = value[TIMER_W-1:0];
      REG_LONG:   long_q     = value[TIMER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [TIME_REG_W-1:0] ta, tb, tc, td,
                              input logic [SLOT_LANES-1:0] en, input logic ch,
                              input logic [TIMER_W-1:0] sh, lg);
    write_reg(REG_SLOT_A, APB_DATA_W'(ta));
    write_reg(REG_SLOT_B, APB_DATA_W'(tb));
    write_reg(REG_SLOT_C, APB_DATA_W'(tc));
    write_reg(REG_SLOT_D, APB_DATA_W'(td));
    write_reg(REG_ENABLE, APB_DATA_W'(en));
    write_reg(REG_CHIME,  APB_DATA_W'(ch));
    write_reg(REG_SHORT,  APB_DATA_W'(sh));
    write_reg(REG_LONG,   APB_DATA_W'(lg));
  endtask

  // half the slots sit on an hour mark so chime and alarm meet
  function automatic logic [SEC_W-1:0] rand_slot_time();
    if ($urandom_range(0, 1) == 0) return SEC_W'($urandom_range(0, 23) * SECS_PER_HOUR);
    return SEC_W'($urandom_range(0, SECS_PER_DAY - 1));
  endfunction

  function automatic logic [TIME_REG_W-1:0] rand_slot_pair();
    return {rand_slot_time(), rand_slot_time()};
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // bursts of random length with random gaps, now and then a long clean run
  task automatic pace();
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = 80;
      end else begin
        idle_cycles($urandom_range(0, 6));
        burst_left = $urandom_range(1, 24);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(input alsb_item_t it, input logic typed, input status_t want);
    status_t predicted;
    @(negedge clk);
    in_chan.valid          <= 1'b1;
    in_chan.mode           <= it.mode;
    in_chan.day_number     <= it.day_number;
    in_chan.seconds_of_day <= it.seconds_of_day;
    in_chan.clock_valid    <= it.clock_valid;
    do @(posedge clk); while (!in_chan.ready);
    predicted = predict_status(it);
    status_q.push_back(typed ? want : predicted);
  endtask

  // stop sending until every outstanding status has come back
  task automatic drain();
    idle_cycles(1);
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // wall clock that walks forward through the days, snapping to hour marks
  task automatic advance_wall_clock();
    int next_sod;
    if ($urandom_range(0, 3) == 0) begin
      next_sod = $urandom_range(0, 23) * SECS_PER_HOUR;
      if (next_sod < wall_sod) wall_day = (wall_day + 1) & 16'hFFFF;
      wall_sod = next_sod;
    end else begin
      wall_sod = wall_sod + $urandom_range(0, 2400);
      if (wall_sod >= SECS_PER_DAY) begin
        wall_sod = wall_sod - SECS_PER_DAY;
        wall_day = (wall_day + 1) & 16'hFFFF;
      end
    end
  endtask

  task automatic random_phase(input int quota);
    alsb_item_t it;
    int         pick;
    int         sent;
    sent = 0;
    while (sent < quota) begin
      pick              = $urandom_range(0, 99);
      it.day_number     = DAY_W'($urandom);
      it.seconds_of_day = SEC_W'($urandom);
      it.clock_valid    = 1'($urandom);
      if (pick < 48) begin
        it.mode = MODE_TICK;
      end else if (pick < 78) begin
        advance_wall_clock();
        it.mode           = MODE_CHECK;
        it.day_number     = DAY_W'(wall_day);
        it.seconds_of_day = SEC_W'(wall_sod);
        it.clock_valid    = ($urandom_range(0, 9) != 0);
      end else if (pick < 88) begin
        it.mode = MODE_ACK;
        if (pick < 86) begin
          it.day_number     = DAY_W'(wall_day);
          it.seconds_of_day = SEC_W'(wall_sod);
        end
      end else if (pick < 95) begin
        // raw time check with any day and any 17-bit seconds value
        it.mode = MODE_CHECK;
      end else begin
        it.mode = MODE_UNUSED;
      end
      if (sent == quota / 2) drain();
      pace();
      send_item(it, 1'b0, '0);
      if (it.mode != MODE_UNUSED) sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    recv_cycle <= recv_cycle + 1;
    case (recv_cycle[8:6])
      3'd0, 3'd1: out_chan.ready <= 1'b1;
      3'd6:       out_chan.ready <= recv_cycle[2];
      3'd7:       out_chan.ready <= ($urandom_range(0, 3) == 0);
      default:    out_chan.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    status_t got;
    status_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.beeper_on, out_chan.active_alarms, out_chan.chime_active};
      if (status_q.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing outstanding", result_count));
      end else begin
        want = status_q.pop_front();
        if (got.beeper !== want.beeper)
          flag_error($sformatf("result %0d beeper_on got %b want %b",
                               result_count, got.beeper, want.beeper));
        if (got.alarms !== want.alarms)
          flag_error($sformatf("result %0d active_alarms got %h want %h",
                               result_count, got.alarms, want.alarms));
        if (got.chime !== want.chime)
          flag_error($sformatf("result %0d chime_active got %b want %b",
                               result_count, got.chime, want.chime));
      end
      result_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    in_chan.valid          = 1'b0;
    in_chan.mode           = MODE_TICK;
    in_chan.day_number     = '0;
    in_chan.seconds_of_day = '0;
    in_chan.clock_valid    = 1'b0;
    error_count            = 0;
    result_count           = 0;
    burst_left             = 0;
    wall_day               = $urandom_range(0, 65535);
    wall_sod               = 0;
    reset_alarm_model();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: slot at midnight, at end of day, out-of-range, on hour marks
    apply_config({17'd86399, 17'd0}, {17'd3600, 17'd131071},
                 {17'd1, 17'd43200}, {17'd86398, 17'd7200},
                 8'hFF, 1'b1, 10'd0, 10'd1);
    for (int r = 0; r < DIR_ROWS; r++) begin
      pace();
      send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
    end

    // random phases, each under new register settings
    for (int ph = 1; ph <= PHASE_COUNT; ph++) begin
      settle();
      case (ph)
        1: apply_config(rand_slot_pair(), rand_slot_pair(), rand_slot_pair(), rand_slot_pair(),
                        8'hFF, 1'b1, 10'd0, 10'd0);
        2: apply_config(rand_slot_pair(), rand_slot_pair(), rand_slot_pair(), rand_slot_pair(),
                        SLOT_LANES'($urandom), 1'b0, 10'd1000, 10'd1000);
        3: apply_config(rand_slot_pair(), rand_slot_pair(), rand_slot_pair(), rand_slot_pair(),
                        SLOT_LANES'($urandom), 1'b1, TIMER_W'($urandom_range(0, 4)),
                        TIMER_W'($urandom_range(0, 20)));
        4: apply_config(rand_slot_pair(), rand_slot_pair(), rand_slot_pair(), rand_slot_pair(),
                        SLOT_LANES'($urandom), 1'b1, TIMER_W'($urandom_range(0, 3)), 10'd1000);
        5: apply_config(rand_slot_pair(), rand_slot_pair(), rand_slot_pair(), rand_slot_pair(),
                        8'hFF, 1'b1, 10'd1000, 10'd0);
        6: apply_config(rand_slot_pair(), rand_slot_pair(), rand_slot_pair(), rand_slot_pair(),
                        8'h00, 1'b1, 10'd1, 10'd3);
        default: apply_config(rand_slot_pair(), rand_slot_pair(), rand_slot_pair(),
                              rand_slot_pair(), 8'hFF, 1'b1, 10'd2, 10'd6);
      endcase
      random_phase(PHASE_ITEMS);
    end

    settle();
    if (error_count == 0 && status_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
